@@ hdl/scio_pkg.sv @@
// Shared types, constants and reset-default functions for the Super I/O configuration port.
package scio_pkg;

  // Register file size and reset chip code.
  localparam int unsigned RegCountDefault  = 16;
  localparam logic [7:0]  ChipVariantReset = 8'h65;

  // Unlock sequence keys and the unlocked count.
  localparam logic [7:0] UnlockKey = 8'h55;
  localparam logic [7:0] LockKey   = 8'haa;
  localparam logic [1:0] Unlocked  = 2'd2;
  localparam logic [7:0] ReadIdle  = 8'hff;

  // Access kind and port codes.
  localparam logic ModeRead  = 1'b0;
  localparam logic ModeWrite = 1'b1;
  localparam logic PortIndex = 1'b0;
  localparam logic PortData  = 1'b1;

  // Configuration register indexes.
  localparam logic CfgChipVariant = 1'b0;
  localparam logic CfgIdePresent  = 1'b1;

  // Chip codes that set defaults and parallel modes.
  localparam logic [7:0] ChipCode61 = 8'h61;
  localparam logic [7:0] ChipCode63 = 8'h63;
  localparam logic [7:0] ChipCode64 = 8'h64;
  localparam logic [7:0] ChipCode65 = 8'h65;
  localparam logic [7:0] ChipCode66 = 8'h66;

  // Register bytes that the decoder looks at.
  typedef struct packed {
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
    logic [7:0] r3;
    logic [7:0] r4;
    logic [7:0] r5;
    logic [7:0] ra;
    logic [7:0] chip_variant;
    logic       ide_present;
  } decode_in_t;

  // Decoded device settings.
  typedef struct packed {
    logic [9:0] uart_a_base;
    logic       uart_a_fast_clock;
    logic [9:0] uart_b_base;
    logic       uart_b_fast_clock;
    logic [9:0] lpt_base;
    logic [2:0] parallel_mode;
    logic [3:0] lpt_fifo_threshold;
    logic [9:0] fdc_base;
    logic [2:0] fdc_drive_control;
    logic       fdc_enhanced;
    logic [9:0] ide_base;
  } decode_out_t;

  // Highest writable register index for a chip code.
  function automatic logic [3:0] last_index(input logic [7:0] v);
    logic [3:0] r;
    if (v == ChipCode63 || v == ChipCode64 || v == ChipCode65 || v == ChipCode66) begin
      r = 4'd15;
    end else if (v >= ChipCode61) begin
      r = 4'd3;
    end else begin
      r = 4'd2;
    end
    return r;
  endfunction

  // Reset value of register i for a chip code.
  function automatic logic [7:0] default_reg(input logic [3:0] i, input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    case (i)
      4'd0: begin
        if (v == ChipCode63 || v == ChipCode65) r = 8'h3b;
        else if (v == ChipCode64 || v == ChipCode66) r = 8'h2b;
        else r = 8'h3f;
      end
      4'd1: r = 8'h9f;
      4'd2: r = 8'hdc;
      4'd3: r = 8'h78;
      4'd6: r = (v >= ChipCode63) ? 8'hff : 8'h00;
      4'd13: r = (v >= ChipCode63) ? v : 8'h00;
      4'd14: begin
        if (v >= ChipCode65) r = 8'h02;
        else if (v >= ChipCode63) r = 8'h01;
        else r = 8'h00;
      end
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/scio_decode.sv @@
// Decodes the configuration registers into serial, parallel, floppy and IDE settings.
module scio_decode (
  input  scio_pkg::decode_in_t  regs_i,
  output scio_pkg::decode_out_t dec_o
);

  logic [9:0] com3;
  logic [9:0] com4;

  // COM3 and COM4 addresses come from register 1 bits 6:5.
  always_comb begin
    case (regs_i.r1[6:5])
      2'd0: begin com3 = 10'h338; com4 = 10'h238; end
      2'd1: begin com3 = 10'h3e8; com4 = 10'h2e8; end
      2'd2: begin com3 = 10'h3e8; com4 = 10'h2e0; end
      default: begin com3 = 10'h220; com4 = 10'h228; end
    endcase
  end

  // Serial base from one nibble of register 2: bit 2 enables, bits 1:0 pick.
  function automatic logic [9:0] uart_base(input logic [3:0] nib, input logic [9:0] c3,
                                           input logic [9:0] c4);
    logic [9:0] b;
    b = 10'h000;
    if (nib[2]) begin
      case (nib[1:0])
        2'd0: b = 10'h3f8;
        2'd1: b = 10'h2f8;
        2'd2: b = c3;
        default: b = c4;
      endcase
    end
    return b;
  endfunction

  // Remaining fields are direct bit decodes.
  always_comb begin
    dec_o.uart_a_base       = uart_base(regs_i.r2[3:0], com3, com4);
    dec_o.uart_a_fast_clock = regs_i.r4[4];
    dec_o.uart_b_base       = uart_base(regs_i.r2[7:4], com3, com4);
    dec_o.uart_b_fast_clock = regs_i.r4[5];

    case (regs_i.r1[1:0])
      2'd1: dec_o.lpt_base = 10'h3bc;
      2'd2: dec_o.lpt_base = 10'h378;
      2'd3: dec_o.lpt_base = 10'h278;
      default: dec_o.lpt_base = 10'h000;
    endcase

    if (regs_i.r1[3]) begin
      dec_o.parallel_mode = 3'd0;
    end else if (regs_i.chip_variant >= scio_pkg::ChipCode65) begin
      dec_o.parallel_mode = 3'd1 + {1'b0, regs_i.r4[1:0]};
    end else begin
      dec_o.parallel_mode = 3'd1;
    end
    dec_o.lpt_fifo_threshold = regs_i.ra[3:0];

    dec_o.fdc_base = regs_i.r0[4] ? (regs_i.r5[0] ? 10'h370 : 10'h3f0) : 10'h000;
    dec_o.fdc_drive_control = {regs_i.r5[5], regs_i.r5[4:3]};
    dec_o.fdc_enhanced = regs_i.r3[1];
    dec_o.ide_base = (regs_i.ide_present && regs_i.r0[0]) ?
                     (regs_i.r5[1] ? 10'h170 : 10'h1f0) : 10'h000;
  end

endmodule

@@ hdl/superio_config_port.sv @@
// Top level of the Super I/O configuration port: unlock logic, register file, result register.
// The result of an access is registered and appears in the cycle after its input transfer.
// One access per cycle when not stalled; the register file and decode update in one pass.
// An output register holds the result; a new transfer is taken whenever it is empty or drained.
// Reset (rst_ni low, asynchronous) locks the port, clears the index, loads the register
// defaults of chip code 0x65, and sets chip_variant to 0x65 and ide_present to 0.
module superio_config_port #(
  parameter int unsigned RegCount = scio_pkg::RegCountDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration write port
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Access channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic       port_select_i,
  input  logic [7:0] write_data_i,
  // Result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [9:0] uart_a_base_o,
  output logic       uart_a_fast_clock_o,
  output logic [9:0] uart_b_base_o,
  output logic       uart_b_fast_clock_o,
  output logic [9:0] lpt_base_o,
  output logic [2:0] parallel_mode_o,
  output logic [3:0] lpt_fifo_threshold_o,
  output logic [9:0] fdc_base_o,
  output logic [2:0] fdc_drive_control_o,
  output logic       fdc_enhanced_o,
  output logic [9:0] ide_base_o
);

  localparam int unsigned IdxW = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam logic [3:0]  LastIdx = scio_pkg::last_index(scio_pkg::ChipVariantReset);

  logic [7:0] chip_variant_q;
  logic       ide_present_q;
  logic [1:0] unlock_q, unlock_d;
  logic [7:0] index_q, index_d;
  logic [7:0] regs_q [RegCount];
  logic [7:0] regs_d [RegCount];
  logic [7:0] view [16];
  logic       out_valid_q;
  logic [7:0] read_data_q;
  logic [7:0] rd_d;
  logic       index_ok;
  logic       in_xfer;
  scio_pkg::decode_in_t  dec_in;
  scio_pkg::decode_out_t dec_out;
  scio_pkg::decode_out_t dec_q;

  // Take a new access when the result register is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_variant_q <= scio_pkg::ChipVariantReset;
      ide_present_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        scio_pkg::CfgChipVariant: chip_variant_q <= cfg_data_i;
        scio_pkg::CfgIdePresent:  ide_present_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The selected index must be within both the limit of the reset chip code and the file size.
  assign index_ok = (index_q <= {4'd0, LastIdx}) && (index_q < 8'(RegCount));

  // Unlock sequence, index selection, register file write and read data for one access.
  always_comb begin
    unlock_d = unlock_q;
    index_d  = index_q;
    regs_d   = regs_q;
    rd_d     = scio_pkg::ReadIdle;
    if (mode_i == scio_pkg::ModeWrite) begin
      if (unlock_q == scio_pkg::Unlocked) begin
        if (port_select_i == scio_pkg::PortIndex) begin
          if (write_data_i == scio_pkg::LockKey) unlock_d = 2'd0;
          else index_d = write_data_i;
        end else if (index_ok) begin
          regs_d[index_q[IdxW-1:0]] = write_data_i;
        end
      end else if (port_select_i == scio_pkg::PortIndex &&
                   write_data_i == scio_pkg::UnlockKey) begin
        unlock_d = unlock_q + 2'd1;
      end
    end else if (unlock_q == scio_pkg::Unlocked && port_select_i == scio_pkg::PortData &&
                 index_ok) begin
      rd_d = regs_q[index_q[IdxW-1:0]];
    end
  end

  // Registers beyond the file size read as zero in the decode.
  always_comb begin
    for (int i = 0; i < 16; i++) view[i] = 8'h00;
    for (int i = 0; i < RegCount; i++) view[i] = regs_d[i];
  end

  assign dec_in.r0           = view[0];
  assign dec_in.r1           = view[1];
  assign dec_in.r2           = view[2];
  assign dec_in.r3           = view[3];
  assign dec_in.r4           = view[4];
  assign dec_in.r5           = view[5];
  assign dec_in.ra           = view[10];
  assign dec_in.chip_variant = chip_variant_q;
  assign dec_in.ide_present  = ide_present_q;

  scio_decode u_decode (
    .regs_i (dec_in),
    .dec_o  (dec_out)
  );

  // Port state and register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unlock_q <= 2'd0;
      index_q  <= 8'h00;
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= scio_pkg::default_reg(4'(i), scio_pkg::ChipVariantReset);
      end
    end else if (in_xfer) begin
      unlock_q <= unlock_d;
      index_q  <= index_d;
      regs_q   <= regs_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      read_data_q <= rd_d;
      dec_q       <= dec_out;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = read_data_q;
  assign uart_a_base_o        = dec_q.uart_a_base;
  assign uart_a_fast_clock_o  = dec_q.uart_a_fast_clock;
  assign uart_b_base_o        = dec_q.uart_b_base;
  assign uart_b_fast_clock_o  = dec_q.uart_b_fast_clock;
  assign lpt_base_o           = dec_q.lpt_base;
  assign parallel_mode_o      = dec_q.parallel_mode;
  assign lpt_fifo_threshold_o = dec_q.lpt_fifo_threshold;
  assign fdc_base_o           = dec_q.fdc_base;
  assign fdc_drive_control_o  = dec_q.fdc_drive_control;
  assign fdc_enhanced_o       = dec_q.fdc_enhanced;
  assign ide_base_o           = dec_q.ide_base;

`ifndef SYNTHESIS
  // The input side only stalls behind a held result.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled with no result held");

  // Every transfer produces a result in the next cycle.
  a_xfer_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o) else $error("transfer produced no result");

  // Write accesses always return the idle byte.
  a_write_reads_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && mode_i == scio_pkg::ModeWrite |=> read_data_o == scio_pkg::ReadIdle)
    else $error("write access returned register data");

  // A locked port never returns register data.
  a_locked_reads_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && unlock_q != scio_pkg::Unlocked |=> read_data_o == scio_pkg::ReadIdle)
    else $error("locked port returned register data");

  // The unlock count stops at the unlocked value.
  a_unlock_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unlock_q != 2'd3) else $error("unlock count overran");
`endif

endmodule
